[rtl/rit_pkg.sv]
// types, codes and helpers shared by the reference-counted entry table
`default_nettype none
package rit_pkg;

  localparam int TABLE_SLOTS_DEF = 64;

  localparam int NUMBER_W = 32;
  localparam int COUNT_W  = 16;
  localparam int SLOT_W   = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_DUP     = 2'd3;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]          command;
    logic [NUMBER_W-1:0] entry_number;
    logic [SLOT_W-1:0]   slot;
  } rit_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot_out;
    logic [COUNT_W-1:0] count_out;
  } rit_res_t;

  typedef struct packed {
    logic                valid;
    logic [NUMBER_W-1:0] number;
    logic [COUNT_W-1:0]  count;
  } rit_entry_t;

  localparam int ENTRY_W = $bits(rit_entry_t);

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

[rtl/rit_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none
module rit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/refcounted_inode_table_unit.sv]
// top level: reference-counted entry table with scan sequencer over one ram
//
//  channel   signals                     direction  beat
//  request   start, busy, request        in         start && !busy
//  result    result_valid, result        out        result_valid, one cycle
//
//  get and alloc scan the slots from index 0, one ram read per cycle.
//  release and dup read the slot, then write it back; a slot beyond the
//  table is answered from the idle state without a ram access.
//  after reset a clearing pass over every slot holds busy high.
//  the result is registered and shown for one cycle; it cannot be stalled.
`default_nettype none
module refcounted_inode_table_unit #(
  parameter int TABLE_SLOTS = rit_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire rit_pkg::rit_req_t request,
  output logic                   result_valid,
  output rit_pkg::rit_res_t      result
);
  import rit_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SLOT  = 4'b1000
  } state_t;

  state_t            state, state_next;
  rit_req_t          req, req_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic              free_found, free_found_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  rit_res_t          result_next;
  logic              result_valid_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  rit_entry_t        rd, wr;

  logic              hit, cur_free, in_range, is_last;
  logic [IDX_W-1:0]  claim_idx, scan_inc;
  logic [COUNT_W-1:0] inc_count, rel_count;

  rit_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd        = rit_entry_t'(ram_rdata);
  assign ram_wdata = ENTRY_W'(wr);
  assign busy      = (state != S_IDLE);

  assign hit       = rd.valid && (rd.number == req.entry_number);
  assign cur_free  = !rd.valid;
  assign is_last   = (scan_idx == LAST);
  assign scan_inc  = is_last ? '0 : scan_idx + IDX_W'(1);
  assign claim_idx = free_found ? free_idx : scan_idx;
  assign in_range  = (32'(request.slot) < 32'(TABLE_SLOTS));
  assign inc_count = sat_inc(rd.count);
  assign rel_count = (rd.count > COUNT_W'(1)) ? rd.count - COUNT_W'(1) : '0;

  always_comb begin
    state_next        = state;
    req_next          = req;
    scan_idx_next     = scan_idx;
    free_found_next   = free_found;
    free_idx_next     = free_idx;
    result_next       = '0;
    result_valid_next = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = scan_idx;
    ram_raddr         = scan_inc;
    wr                = '0;
    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        scan_idx_next = scan_inc;
        if (is_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          req_next        = request;
          scan_idx_next   = '0;
          free_found_next = 1'b0;
          if (request.command == CMD_GET || request.command == CMD_ALLOC) begin
            state_next = S_SCAN;
          end else if (in_range) begin
            ram_raddr  = IDX_W'(request.slot);
            state_next = S_SLOT;
          end else begin
            result_valid_next = 1'b1;
            result_next       = '{status: ST_DONE, slot_out: request.slot, count_out: '0};
          end
        end
      end
      S_SCAN: begin
        scan_idx_next = scan_inc;
        if (req.command == CMD_GET) begin
          if (hit) begin
            ram_we            = 1'b1;
            wr                = '{valid: 1'b1, number: rd.number, count: inc_count};
            result_valid_next = 1'b1;
            result_next       = '{status: ST_HIT, slot_out: SLOT_W'(scan_idx),
                                  count_out: inc_count};
            state_next        = S_IDLE;
          end else begin
            if (cur_free && !free_found) begin
              free_found_next = 1'b1;
              free_idx_next   = scan_idx;
            end
            if (is_last) begin
              result_valid_next = 1'b1;
              state_next        = S_IDLE;
              if (free_found || cur_free) begin
                ram_we      = 1'b1;
                ram_waddr   = claim_idx;
                wr          = '{valid: 1'b1, number: req.entry_number, count: COUNT_W'(1)};
                result_next = '{status: ST_LOAD, slot_out: SLOT_W'(claim_idx),
                                count_out: COUNT_W'(1)};
              end else begin
                result_next = '{status: ST_FULL, slot_out: '0, count_out: '0};
              end
            end
          end
        end else begin
          if (cur_free) begin
            ram_we            = 1'b1;
            wr                = '{valid: 1'b1, number: rd.number, count: COUNT_W'(1)};
            result_valid_next = 1'b1;
            result_next       = '{status: ST_DONE, slot_out: SLOT_W'(scan_idx),
                                  count_out: COUNT_W'(1)};
            state_next        = S_IDLE;
          end else if (is_last) begin
            result_valid_next = 1'b1;
            result_next       = '{status: ST_FULL, slot_out: '0, count_out: '0};
            state_next        = S_IDLE;
          end
        end
      end
      S_SLOT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(req.slot);
        if (req.command == CMD_RELEASE) begin
          wr = '{valid: rd.valid && (rd.count > COUNT_W'(1)), number: rd.number,
                 count: rel_count};
        end else begin
          wr = '{valid: rd.valid, number: rd.number, count: inc_count};
        end
        result_valid_next = 1'b1;
        result_next       = '{status: ST_DONE, slot_out: req.slot, count_out: wr.count};
        state_next        = S_IDLE;
      end
      default: begin
        state_next    = S_CLEAR;
        scan_idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      scan_idx     <= '0;
      free_found   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      scan_idx     <= scan_idx_next;
      free_found   <= free_found_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    free_idx <= free_idx_next;
    result   <= result_next;
  end

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !result_valid)
    else $error("result beat during clearing pass");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_valid))
    else $error("accepted request neither busy nor answered");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_FULL) |->
      (result.slot_out == '0 && result.count_out == '0))
    else $error("full result carries nonzero slot or count");

  a_load_count_one: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_LOAD) |-> (result.count_out == COUNT_W'(1)))
    else $error("newly claimed slot without count of one");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_SCAN || state == S_SLOT))
    else $error("ram write while idle");

endmodule
`default_nettype wire
